// ===== hw/rtl/lobe_pkg.sv =====
// Shared types and constants for the limit order book engine.
// Holds request and status codes and the packed stream payload layouts.
// No dependencies.
package lobe_pkg;

    localparam int ORDER_SLOTS_DEF     = 1024;
    localparam int LEVELS_PER_SIDE_DEF = 256;
    localparam int SUM_W               = 42;
    localparam int SDATA_W             = 104;
    localparam int MDATA_W             = 240;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_QUERY  = 3'd3,
        REQ_FILL   = 3'd4,
        REQ_SET    = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4,
        ST_OVERFILL = 3'd5
    } t_status;

    // Input payload, lowest field last in the list (packed from bit 0 up).
    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] quantity;
        logic [31:0] price;
        logic        side;
        logic [31:0] order_id;
    } t_sdata;

    // Result payload, packed from bit 0 up in reverse list order.
    typedef struct packed {
        logic [2:0]       pad;
        logic [31:0]      best_ask;
        logic             ask_valid;
        logic [31:0]      best_bid;
        logic             bid_valid;
        logic [31:0]      front_remaining;
        logic [31:0]      front_id;
        logic [SUM_W-1:0] level_total;
        logic [31:0]      order_remaining;
        logic [31:0]      order_price;
        logic             order_side;
    } t_mdata;

endpackage

// ===== hw/rtl/lobe_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the order slot store and the price level store. No dependencies.
module lobe_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/limit_order_book_engine.sv =====
// Operation: a request runs a scan of the slot store (not for query and fill), a scan of
// the price levels of one side, then read-modify-write steps, a walk over the orders
// ahead of a removed one, and a best price scan of both sides when a level appears or
// vanishes. Throughput: one request in work at a time; the next is accepted once the
// result is registered. Reset: synchronous, active low; then a clearing pass zeroes both
// stores with s_axis_tready low.
module limit_order_book_engine #(
    parameter int ORDER_SLOTS     = lobe_pkg::ORDER_SLOTS_DEF,
    parameter int LEVELS_PER_SIDE = lobe_pkg::LEVELS_PER_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // order_id[31:0], side[32], price[64:33], quantity[96:65]
    input  logic [lobe_pkg::SDATA_W-1:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // order_side[0], order_price[32:1], order_remaining[64:33], level_total[106:65],
    // front_id[138:107], front_remaining[170:139], bid_valid[171], best_bid[203:172],
    // ask_valid[204], best_ask[236:205]
    output logic [lobe_pkg::MDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]                   m_axis_tuser
);

    localparam int SW   = $clog2(ORDER_SLOTS);
    localparam int NLV  = 2 * LEVELS_PER_SIDE;
    localparam int LW   = $clog2(NLV);
    localparam int MAXD = (ORDER_SLOTS > NLV) ? ORDER_SLOTS : NLV;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int SUMW = lobe_pkg::SUM_W;

    typedef struct packed {
        logic          used;
        logic [31:0]   ident;
        logic          side;
        logic [31:0]   price;
        logic [31:0]   left;
        logic [SW-1:0] next;
    } t_slot;

    typedef struct packed {
        logic            used;
        logic [31:0]     price;
        logic [SUMW-1:0] sum;
        logic [SW-1:0]   head;
        logic [SW-1:0]   tail;
    } t_level;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SSCAN, S_SDONE, S_LSCAN, S_LDONE, S_TAIL_RD, S_TAIL_WR,
        S_LVWR, S_SWR, S_FRONT_RD, S_FRONT_GET, S_FH_RD, S_FH_CHK, S_UNL,
        S_WALK_RD, S_WALK_CHK, S_FIN, S_BSCAN, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_paddr;
    logic          r_pend;

    lobe_pkg::t_req    r_req;
    lobe_pkg::t_status r_status;
    lobe_pkg::t_sdata  w_in;
    lobe_pkg::t_mdata  w_out;

    logic [31:0] r_id, r_price, r_qty, r_tprice;
    logic        r_side;

    logic          r_hit, r_free_ok;
    logic [SW-1:0] r_s, r_free, r_prev;
    t_slot         r_sl;

    logic          r_lhit, r_lfree_ok;
    logic [LW-1:0] r_lv, r_lfree, r_base;
    t_level        r_le;
    logic          r_relevel;

    logic        r_bv, r_av;
    logic [31:0] r_bb, r_ba;

    logic            r_os;
    logic [31:0]     r_op, r_orem, r_fid, r_frem;
    logic [SUMW-1:0] r_lt;

    logic                         r_ovalid;
    logic [lobe_pkg::MDATA_W-1:0] r_odata;
    logic [2:0]                   r_ouser;

    logic          s_we, s_re;
    logic [SW-1:0] s_waddr, s_raddr;
    t_slot         s_wdata, s_q;
    logic          l_we, l_re;
    logic [LW-1:0] l_waddr, l_raddr;
    t_level        l_wdata, l_q;

    lobe_ram #(.DEPTH(ORDER_SLOTS), .WIDTH($bits(t_slot))) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_q)
    );

    lobe_ram #(.DEPTH(NLV), .WIDTH($bits(t_level))) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_q)
    );

    assign w_in          = s_axis_tdata;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_comb begin
        w_out                 = '0;
        w_out.order_side      = r_os;
        w_out.order_price     = r_op;
        w_out.order_remaining = r_orem;
        w_out.level_total     = r_lt;
        w_out.front_id        = r_fid;
        w_out.front_remaining = r_frem;
        w_out.bid_valid       = r_bv;
        w_out.best_bid        = r_bb;
        w_out.ask_valid       = r_av;
        w_out.best_ask        = r_ba;
    end

    // Memory port steering
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_s;
        s_wdata = r_sl;
        s_re    = 1'b0;
        s_raddr = '0;
        l_we    = 1'b0;
        l_waddr = r_lv;
        l_wdata = r_le;
        l_re    = 1'b0;
        l_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                s_we    = (r_cnt < CW'(ORDER_SLOTS));
                s_waddr = r_cnt[SW-1:0];
                s_wdata = '0;
                l_we    = (r_cnt < CW'(NLV));
                l_waddr = r_cnt[LW-1:0];
                l_wdata = '0;
            end
            S_SSCAN: begin
                s_re    = (r_cnt < CW'(ORDER_SLOTS));
                s_raddr = r_cnt[SW-1:0];
            end
            S_LSCAN: begin
                l_re    = (r_cnt < CW'(LEVELS_PER_SIDE));
                l_raddr = r_base + r_cnt[LW-1:0];
            end
            S_BSCAN: begin
                l_re    = (r_cnt < CW'(NLV));
                l_raddr = r_cnt[LW-1:0];
            end
            S_TAIL_RD: begin
                s_re    = 1'b1;
                s_raddr = r_le.tail;
            end
            S_TAIL_WR: begin
                s_we         = 1'b1;
                s_waddr      = r_le.tail;
                s_wdata      = s_q;
                s_wdata.next = r_s;
            end
            S_LVWR: begin
                l_we = r_lhit;
            end
            S_SWR: begin
                s_we = 1'b1;
            end
            S_FRONT_RD: begin
                s_re    = r_le.used;
                s_raddr = r_le.head;
            end
            S_FH_RD: begin
                s_re    = 1'b1;
                s_raddr = r_le.head;
            end
            S_WALK_RD: begin
                s_re    = 1'b1;
                s_raddr = r_prev;
            end
            S_WALK_CHK: begin
                s_we         = (s_q.next == r_s);
                s_waddr      = r_prev;
                s_wdata      = s_q;
                s_wdata.next = r_sl.next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_relevel <= 1'b0;
            r_bv      <= 1'b0;
            r_av      <= 1'b0;
            r_bb      <= '0;
            r_ba      <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MAXD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req      <= lobe_pkg::t_req'(s_axis_tuser);
                        r_id       <= w_in.order_id;
                        r_side     <= w_in.side;
                        r_price    <= w_in.price;
                        r_qty      <= w_in.quantity;
                        r_status   <= lobe_pkg::ST_OK;
                        r_os       <= 1'b0;
                        r_op       <= '0;
                        r_orem     <= '0;
                        r_lt       <= '0;
                        r_fid      <= '0;
                        r_frem     <= '0;
                        r_hit      <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_lhit     <= 1'b0;
                        r_lfree_ok <= 1'b0;
                        r_le       <= '0;
                        r_cnt      <= '0;
                        r_pend     <= 1'b0;
                        r_tprice   <= w_in.price;
                        r_base     <= w_in.side ? LW'(LEVELS_PER_SIDE) : '0;
                        case (s_axis_tuser) inside
                            lobe_pkg::REQ_INSERT, lobe_pkg::REQ_REMOVE,
                            lobe_pkg::REQ_LOOKUP, lobe_pkg::REQ_SET: r_state <= S_SSCAN;
                            lobe_pkg::REQ_QUERY, lobe_pkg::REQ_FILL: r_state <= S_LSCAN;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_SSCAN: begin
                    if (r_cnt < CW'(ORDER_SLOTS)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_pend  <= (r_cnt < CW'(ORDER_SLOTS));
                    r_paddr <= r_cnt;
                    if (r_pend) begin
                        if (s_q.used && s_q.ident == r_id && !r_hit) begin
                            r_hit <= 1'b1;
                            r_s   <= r_paddr[SW-1:0];
                            r_sl  <= s_q;
                        end
                        if (!s_q.used && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_paddr[SW-1:0];
                        end
                    end
                    if (r_cnt == CW'(ORDER_SLOTS) && !r_pend) begin
                        r_state <= S_SDONE;
                    end
                end
                S_SDONE: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    if (r_req == lobe_pkg::REQ_INSERT) begin
                        if (r_hit) begin
                            r_status <= lobe_pkg::ST_EXISTS;
                            r_state  <= S_FIN;
                        end else if (!r_free_ok) begin
                            r_status <= lobe_pkg::ST_FULL;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_LSCAN;
                        end
                    end else if (!r_hit) begin
                        r_status <= lobe_pkg::ST_UNKNOWN;
                        r_state  <= S_FIN;
                    end else begin
                        r_os     <= r_sl.side;
                        r_op     <= r_sl.price;
                        r_orem   <= (r_req == lobe_pkg::REQ_SET) ? r_qty : r_sl.left;
                        r_tprice <= r_sl.price;
                        r_base   <= r_sl.side ? LW'(LEVELS_PER_SIDE) : '0;
                        r_state  <= S_LSCAN;
                    end
                end
                S_LSCAN: begin
                    if (r_cnt < CW'(LEVELS_PER_SIDE)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_pend  <= (r_cnt < CW'(LEVELS_PER_SIDE));
                    r_paddr <= r_cnt;
                    if (r_pend) begin
                        if (l_q.used && l_q.price == r_tprice && !r_lhit) begin
                            r_lhit <= 1'b1;
                            r_lv   <= r_base + r_paddr[LW-1:0];
                            r_le   <= l_q;
                        end
                        if (!l_q.used && !r_lfree_ok) begin
                            r_lfree_ok <= 1'b1;
                            r_lfree    <= r_base + r_paddr[LW-1:0];
                        end
                    end
                    if (r_cnt == CW'(LEVELS_PER_SIDE) && !r_pend) begin
                        r_state <= S_LDONE;
                    end
                end
                S_LDONE: begin
                    case (r_req)
                        lobe_pkg::REQ_INSERT: begin
                            r_sl <= '{used: 1'b1, ident: r_id, side: r_side, price: r_price,
                                      left: r_qty, next: '0};
                            r_s  <= r_free;
                            if (r_lhit) begin
                                r_os    <= r_side;
                                r_op    <= r_price;
                                r_orem  <= r_qty;
                                r_state <= S_TAIL_RD;
                            end else if (!r_lfree_ok) begin
                                r_status <= lobe_pkg::ST_FULL;
                                r_state  <= S_FIN;
                            end else begin
                                r_os      <= r_side;
                                r_op      <= r_price;
                                r_orem    <= r_qty;
                                r_lhit    <= 1'b1;
                                r_lv      <= r_lfree;
                                r_le      <= '{used: 1'b1, price: r_price,
                                               sum: {{(SUMW-32){1'b0}}, r_qty},
                                               head: r_free, tail: r_free};
                                r_relevel <= 1'b1;
                                r_state   <= S_LVWR;
                            end
                        end
                        lobe_pkg::REQ_REMOVE: begin
                            if (r_lhit) begin
                                r_state <= S_UNL;
                            end else begin
                                r_sl.used <= 1'b0;
                                r_state   <= S_SWR;
                            end
                        end
                        lobe_pkg::REQ_LOOKUP: r_state <= S_FRONT_RD;
                        lobe_pkg::REQ_QUERY: begin
                            if (r_lhit) begin
                                r_state <= S_FRONT_RD;
                            end else begin
                                r_status <= lobe_pkg::ST_MISSING;
                                r_state  <= S_FIN;
                            end
                        end
                        lobe_pkg::REQ_FILL: begin
                            if (r_lhit) begin
                                r_state <= S_FH_RD;
                            end else begin
                                r_status <= lobe_pkg::ST_MISSING;
                                r_state  <= S_FIN;
                            end
                        end
                        lobe_pkg::REQ_SET: begin
                            if (r_lhit) begin
                                r_le.sum <= r_le.sum - {{(SUMW-32){1'b0}}, r_sl.left}
                                            + {{(SUMW-32){1'b0}}, r_qty};
                            end
                            r_sl.left <= r_qty;
                            r_state   <= S_LVWR;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_TAIL_RD: r_state <= S_TAIL_WR;
                S_TAIL_WR: begin
                    // append the new slot behind the old tail
                    r_le.tail <= r_s;
                    r_le.sum  <= r_le.sum + {{(SUMW-32){1'b0}}, r_qty};
                    r_state   <= S_LVWR;
                end
                S_LVWR: r_state <= S_SWR;
                S_SWR: r_state <= S_FRONT_RD;
                S_FRONT_RD: r_state <= r_le.used ? S_FRONT_GET : S_FIN;
                S_FRONT_GET: begin
                    r_lt    <= r_le.sum;
                    r_fid   <= s_q.ident;
                    r_frem  <= s_q.left;
                    r_state <= S_FIN;
                end
                S_FH_RD: begin
                    r_s     <= r_le.head;
                    r_state <= S_FH_CHK;
                end
                S_FH_CHK: begin
                    if (r_qty > s_q.left) begin
                        r_status <= lobe_pkg::ST_OVERFILL;
                        r_lt     <= r_le.sum;
                        r_fid    <= s_q.ident;
                        r_frem   <= s_q.left;
                        r_state  <= S_FIN;
                    end else begin
                        r_sl     <= '{used: s_q.used, ident: s_q.ident, side: s_q.side,
                                      price: s_q.price, left: s_q.left - r_qty,
                                      next: s_q.next};
                        r_le.sum <= r_le.sum - {{(SUMW-32){1'b0}}, r_qty};
                        r_state  <= (s_q.left == r_qty) ? S_UNL : S_LVWR;
                    end
                end
                S_UNL: begin
                    r_le.sum  <= r_le.sum - {{(SUMW-32){1'b0}}, r_sl.left};
                    r_sl.used <= 1'b0;
                    if (r_le.head == r_s) begin
                        if (r_le.tail == r_s) begin
                            r_le.used <= 1'b0;
                            r_relevel <= 1'b1;
                        end else begin
                            r_le.head <= r_sl.next;
                        end
                        r_state <= S_LVWR;
                    end else begin
                        r_prev  <= r_le.head;
                        r_state <= S_WALK_RD;
                    end
                end
                S_WALK_RD: r_state <= S_WALK_CHK;
                S_WALK_CHK: begin
                    // predecessor found: its link is rewritten by the port logic
                    if (s_q.next == r_s) begin
                        if (r_le.tail == r_s) begin
                            r_le.tail <= r_prev;
                        end
                        r_state <= S_LVWR;
                    end else begin
                        r_prev  <= s_q.next;
                        r_state <= S_WALK_RD;
                    end
                end
                S_FIN: begin
                    if (r_relevel) begin
                        r_relevel <= 1'b0;
                        r_cnt     <= '0;
                        r_pend    <= 1'b0;
                        r_bv      <= 1'b0;
                        r_av      <= 1'b0;
                        r_bb      <= '0;
                        r_ba      <= '0;
                        r_state   <= S_BSCAN;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_BSCAN: begin
                    if (r_cnt < CW'(NLV)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_pend  <= (r_cnt < CW'(NLV));
                    r_paddr <= r_cnt;
                    if (r_pend && l_q.used) begin
                        if (r_paddr < CW'(LEVELS_PER_SIDE)) begin
                            if (!r_bv || l_q.price > r_bb) begin
                                r_bv <= 1'b1;
                                r_bb <= l_q.price;
                            end
                        end else if (!r_av || l_q.price < r_ba) begin
                            r_av <= 1'b1;
                            r_ba <= l_q.price;
                        end
                    end
                    if (r_cnt == CW'(NLV) && !r_pend) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata <= w_out;
                        r_ouser <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/lobe_chk.sv =====
// Port-level checker for the limit order book engine, bound to the top level.
// Depends on lobe_pkg for the result layout and status codes.
module lobe_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lobe_pkg::MDATA_W-1:0] m_axis_tdata,
    input logic [2:0]                   m_axis_tuser
);

    lobe_pkg::t_mdata w_res;
    assign w_res = m_axis_tdata;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_res.bid_valid || w_res.best_bid == '0) &&
                          (w_res.ask_valid || w_res.best_ask == '0))
        else $error("best price set without its valid bit");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == lobe_pkg::ST_EXISTS ||
                          m_axis_tuser == lobe_pkg::ST_UNKNOWN ||
                          m_axis_tuser == lobe_pkg::ST_MISSING ||
                          m_axis_tuser == lobe_pkg::ST_FULL) |->
            !w_res.order_side && w_res.order_price == '0 && w_res.order_remaining == '0 &&
            w_res.level_total == '0 && w_res.front_id == '0 && w_res.front_remaining == '0)
        else $error("refused request reports order or level data");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind limit_order_book_engine lobe_chk u_lobe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
